[design/vsvf_pkg.sv]
package vsvf_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLICES = 2'd2;

  // Dimension register value after reset, before clamping.
  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  // Width of the coordinate fields of a result.
  localparam int COORD_W = 6;

  // Voxel classes.
  localparam int CLASS_W = 2;
  localparam logic [CLASS_W-1:0] CLASS_ZERO  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_ONE   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_OTHER = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_RSVD  = 2'd3;

  // One memory word holds the class of one voxel position in both plane slots.
  localparam int WORD_W = 2 * CLASS_W;

  // Status of the current scan position, from the scan controller to the decision logic.
  typedef struct packed {
    logic in_volume;   // position lies inside the volume, so it is stored
    logic has_result;  // the voxel one plane back gets decided now
    logic row_lo;      // row above is in bounds
    logic row_hi;      // row below is in bounds
    logic col_lo;      // column to the left is in bounds
    logic col_hi;      // column to the right is in bounds
    logic slice_lo;    // previous plane of the decided voxel is in bounds
    logic last;        // decided voxel is the final voxel of the volume
  } vsvf_flags_t;

endpackage

[design/vsvf_plane_bank.sv]
module vsvf_plane_bank
  import vsvf_pkg::*;
#(
  parameter int AW = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  output logic [WORD_W-1:0] rd_data_a,
  output logic [WORD_W-1:0] rd_data_b
);

  logic [WORD_W-1:0] mem [2**AW];
  logic [WORD_W-1:0] rd_q_a;
  logic [WORD_W-1:0] rd_q_b;
  logic [AW-1:0]     ra_a;
  logic [AW-1:0]     ra_b;
  logic              fw_valid;
  logic [AW-1:0]     fw_addr;
  logic [WORD_W-1:0] fw_data;

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two read ports, re-read every cycle, with their addresses kept for the bypass compare.
  always_ff @(posedge clk) begin
    rd_q_a  <= mem[rd_addr_a];
    rd_q_b  <= mem[rd_addr_b];
    ra_a    <= rd_addr_a;
    ra_b    <= rd_addr_b;
    fw_addr <= wr_addr;
    fw_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else begin
      fw_valid <= wr_en;
    end
  end

  // A read issued in the same cycle as a write to that entry returned the old word.
  // The last write is kept in a register and replaces it.
  assign rd_data_a = (fw_valid && (fw_addr == ra_a)) ? fw_data : rd_q_a;
  assign rd_data_b = (fw_valid && (fw_addr == ra_b)) ? fw_data : rd_q_b;

endmodule

[design/vsvf_scan_ctrl.sv]
module vsvf_scan_ctrl
  import vsvf_pkg::*;
#(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int MAX_SLICES = 64,
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RDW = $clog2(MAX_ROWS + 1),
  localparam int CDW = $clog2(MAX_COLS + 1),
  localparam int SW  = $clog2(MAX_SLICES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  output logic [RW-1:0]        cur_row,
  output logic [CW-1:0]        cur_col,
  output logic [SW-1:0]        cur_slice,
  output logic [RW-1:0]        rd_row,
  output logic [CW-1:0]        rd_col,
  output vsvf_flags_t          flags
);

  logic [RDW-1:0] rows_in_use;
  logic [CDW-1:0] cols_in_use;
  logic [SW-1:0]  slices_in_use;

  logic [RW:0]   row_inc;
  logic [CW:0]   col_inc;
  logic [SW:0]   slice_inc;
  logic          row_wrap;
  logic          col_wrap;
  logic          slice_wrap;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_next;
  logic [SW-1:0] slice_next;
  logic          cfg_hit;

  // A zero dimension acts as one, and one above the maximum acts as the maximum.
  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    int r;
    if (v == '0) begin
      r = 1;
    end else if (int'(v) > maxv) begin
      r = maxv;
    end else begin
      r = int'(v);
    end
    return r;
  endfunction

  // Next scan position: column fastest, then row, then slice, with one extra flush plane.
  always_comb begin
    col_inc    = (CW + 1)'(cur_col) + 1'b1;
    row_inc    = (RW + 1)'(cur_row) + 1'b1;
    slice_inc  = (SW + 1)'(cur_slice) + 1'b1;
    col_wrap   = col_inc >= (CW + 1)'(cols_in_use);
    row_wrap   = row_inc >= (RW + 1)'(rows_in_use);
    slice_wrap = slice_inc > (SW + 1)'(slices_in_use);
    col_next   = col_wrap ? '0 : CW'(col_inc);
    row_next   = cur_row;
    slice_next = cur_slice;
    if (col_wrap) begin
      row_next = row_wrap ? '0 : RW'(row_inc);
      if (row_wrap) begin
        slice_next = slice_wrap ? '0 : SW'(slice_inc);
      end
    end
  end

  assign cfg_hit = cfg_we && ((cfg_index == REG_ROWS) || (cfg_index == REG_COLS) ||
                              (cfg_index == REG_SLICES));

  // Dimension registers and position counters; any register write restarts the volume.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use   <= RDW'(clamp_dim(DIM_RESET, MAX_ROWS));
      cols_in_use   <= CDW'(clamp_dim(DIM_RESET, MAX_COLS));
      slices_in_use <= SW'(clamp_dim(DIM_RESET, MAX_SLICES));
      cur_row       <= '0;
      cur_col       <= '0;
      cur_slice     <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        REG_ROWS:   rows_in_use   <= RDW'(clamp_dim(cfg_data, MAX_ROWS));
        REG_COLS:   cols_in_use   <= CDW'(clamp_dim(cfg_data, MAX_COLS));
        REG_SLICES: slices_in_use <= SW'(clamp_dim(cfg_data, MAX_SLICES));
        default:    rows_in_use   <= rows_in_use;
      endcase
      cur_row   <= '0;
      cur_col   <= '0;
      cur_slice <= '0;
    end else if (accept) begin
      cur_row   <= row_next;
      cur_col   <= col_next;
      cur_slice <= slice_next;
    end
  end

  // Memory reads look at the position that will be current after this edge; reset and a
  // register write both restart the scan at the origin.
  assign rd_row = (rst || cfg_hit) ? '0 : (accept ? row_next : cur_row);
  assign rd_col = (rst || cfg_hit) ? '0 : (accept ? col_next : cur_col);

  // Bounds and status of the current position.
  always_comb begin
    flags.in_volume  = cur_slice < slices_in_use;
    flags.has_result = cur_slice != '0;
    flags.row_lo     = cur_row != '0;
    flags.row_hi     = row_inc < (RW + 1)'(rows_in_use);
    flags.col_lo     = cur_col != '0;
    flags.col_hi     = col_inc < (CW + 1)'(cols_in_use);
    flags.slice_lo   = cur_slice > SW'(1);
    flags.last       = (row_inc == (RW + 1)'(rows_in_use)) &&
                       (col_inc == (CW + 1)'(cols_in_use)) &&
                       (cur_slice == slices_in_use);
  end

endmodule

[design/volume_surface_voxel_finder_unit.sv]
// Latency: a result is registered at the edge that accepts the item one plane later at the
//   same row and column, and is shown from the next cycle on; items of the first plane give none.
// Throughput: one item per cycle when not stalled; each of the two row-parity memory banks serves two reads
//   and one write per cycle, which covers the five-point neighbourhood of every voxel.
// Reset: position counters return to zero, dimensions to 64 (clamped to the maxima) and the
//   output register empties; the plane memories are not cleared and need no clearing pass.
module volume_surface_voxel_finder_unit
  import vsvf_pkg::*;
#(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int MAX_SLICES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CLASS_W-1:0]   label_class,
  input  logic                 flush,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COORD_W-1:0]   row,
  output logic [COORD_W-1:0]   col,
  output logic [COORD_W-1:0]   slice,
  output logic                 on_boundary,
  output logic                 last_voxel
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW  = $clog2(MAX_SLICES + 1);
  localparam int RHW = (RW > 1) ? RW - 1 : 1;
  localparam int AW  = RHW + CW;

  logic              in_accept;
  logic [RW-1:0]     cur_row;
  logic [CW-1:0]     cur_col;
  logic [SW-1:0]     cur_slice;
  logic [RW-1:0]     rd_row;
  logic [CW-1:0]     rd_col;
  vsvf_flags_t       flags;

  logic [RW-1:0]     rd_row_up;
  logic [RW-1:0]     rd_row_dn;
  logic [CW-1:0]     rd_col_rt;
  logic [AW-1:0]     addr_ctr;
  logic [AW-1:0]     addr_rt;
  logic [AW-1:0]     addr_up;
  logic [AW-1:0]     addr_dn;
  logic [AW-1:0]     rd_addr_a [2];
  logic [AW-1:0]     rd_addr_b [2];
  logic [WORD_W-1:0] rd_data_a [2];
  logic [WORD_W-1:0] rd_data_b [2];
  logic              wr_en [2];
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_word;

  logic [WORD_W-1:0] w_ctr;
  logic [WORD_W-1:0] w_rt;
  logic [WORD_W-1:0] w_up;
  logic [WORD_W-1:0] w_dn;
  logic [WORD_W-1:0] w_lt;
  logic              ps;
  logic [CLASS_W-1:0] cls;
  logic              hit;

  // Word address inside a row-parity bank.
  function automatic logic [AW-1:0] bank_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return {RHW'(r >> 1), c};
  endfunction

  // Class held in one plane slot of a word.
  function automatic logic [CLASS_W-1:0] slot_get(input logic [WORD_W-1:0] w, input logic s);
    return s ? w[WORD_W-1:CLASS_W] : w[CLASS_W-1:0];
  endfunction

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  vsvf_scan_ctrl #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_SLICES (MAX_SLICES)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (in_accept),
    .cur_row   (cur_row),
    .cur_col   (cur_col),
    .cur_slice (cur_slice),
    .rd_row    (rd_row),
    .rd_col    (rd_col),
    .flags     (flags)
  );

  // Neighbourhood addresses. The centre row and its right neighbour sit in the bank of the
  // row's parity; the rows above and below sit in the other bank. Out-of-range addresses
  // only feed neighbours that the bounds flags mask.
  always_comb begin
    rd_row_up = rd_row - 1'b1;
    rd_row_dn = rd_row + 1'b1;
    rd_col_rt = rd_col + 1'b1;
    addr_ctr  = bank_addr(rd_row, rd_col);
    addr_rt   = bank_addr(rd_row, rd_col_rt);
    addr_up   = bank_addr(rd_row_up, rd_col);
    addr_dn   = bank_addr(rd_row_dn, rd_col);
    rd_addr_a[0] = rd_row[0] ? addr_up : addr_ctr;
    rd_addr_b[0] = rd_row[0] ? addr_dn : addr_rt;
    rd_addr_a[1] = rd_row[0] ? addr_ctr : addr_up;
    rd_addr_b[1] = rd_row[0] ? addr_rt : addr_dn;
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    vsvf_plane_bank #(
      .AW (AW)
    ) u_bank (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (wr_en[b]),
      .wr_addr   (wr_addr),
      .wr_data   (wr_word),
      .rd_addr_a (rd_addr_a[b]),
      .rd_addr_b (rd_addr_b[b]),
      .rd_data_a (rd_data_a[b]),
      .rd_data_b (rd_data_b[b])
    );
  end

  // Read data belongs to the current position; route it back by row parity.
  always_comb begin
    w_ctr = cur_row[0] ? rd_data_a[1] : rd_data_a[0];
    w_rt  = cur_row[0] ? rd_data_b[1] : rd_data_b[0];
    w_up  = cur_row[0] ? rd_data_a[0] : rd_data_a[1];
    w_dn  = cur_row[0] ? rd_data_b[0] : rd_data_b[1];
  end

  // The left neighbour is the centre word of the previous transaction in the same row.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      w_lt <= w_ctr;
    end
  end

  // Decide the voxel one plane back. Its plane lives in the slot opposite the current
  // slice parity; the plane before it shares the slot about to be overwritten.
  always_comb begin
    ps  = ~cur_slice[0];
    cls = (flush || (label_class == CLASS_RSVD)) ? CLASS_OTHER : label_class;
    hit = (slot_get(w_ctr, ps) == CLASS_ONE) &&
          ((flags.row_hi   && (slot_get(w_dn, ps) == CLASS_ZERO)) ||
           (flags.row_lo   && (slot_get(w_up, ps) == CLASS_ZERO)) ||
           (flags.col_hi   && (slot_get(w_rt, ps) == CLASS_ZERO)) ||
           (flags.col_lo   && (slot_get(w_lt, ps) == CLASS_ZERO)) ||
           (flags.in_volume && (cls == CLASS_ZERO)) ||
           (flags.slice_lo && (slot_get(w_ctr, ~ps) == CLASS_ZERO)));
  end

  // Write back the centre word with the incoming class in the current slice's slot.
  always_comb begin
    wr_addr  = bank_addr(cur_row, cur_col);
    wr_word  = cur_slice[0] ? {cls, w_ctr[CLASS_W-1:0]} : {w_ctr[WORD_W-1:CLASS_W], cls};
    wr_en[0] = in_accept && flags.in_volume && !cur_row[0];
    wr_en[1] = in_accept && flags.in_volume && cur_row[0];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= flags.has_result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && flags.has_result) begin
      row         <= COORD_W'(cur_row);
      col         <= COORD_W'(cur_col);
      slice       <= COORD_W'(cur_slice - 1'b1);
      on_boundary <= hit;
      last_voxel  <= flags.last;
    end
  end

endmodule

[design/vsvf_checker.sv]
module vsvf_checker
  import vsvf_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COORD_W-1:0] row,
  input logic [COORD_W-1:0] col,
  input logic [COORD_W-1:0] slice,
  input logic               on_boundary,
  input logic               last_voxel
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // The input side waits only behind a result that is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // A new result appears only after an input transaction.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an input transaction");

  // A held result keeps its payload.
  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(row) && $stable(col) &&
                                  $stable(slice) && $stable(on_boundary) &&
                                  $stable(last_voxel)))
    else $error("held result changed");

endmodule

bind volume_surface_voxel_finder_unit vsvf_checker u_vsvf_checker (.*);

[tb/tb_volume_surface_voxel_finder_unit.sv]
`timescale 1ns / 1ps

module tb_volume_surface_voxel_finder_unit;
  import vsvf_pkg::*;

  localparam int MAX_DIM = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int STARVE_CYCLES = 300;
  localparam int ITEM_TARGET = 800;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One voxel offered to the block.
  typedef struct packed {
    logic [CLASS_W-1:0] label;
    logic               padding;
  } voxel_item_t;

  // One decided voxel as the block should report it.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] slice;
    logic               on_boundary;
    logic               last_voxel;
  } voxel_verdict_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CLASS_W-1:0] label_class = '0;
  logic               flush = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] slice;
  logic               on_boundary;
  logic               last_voxel;

  // Stimulus and expectation stores.
  voxel_item_t    feed_q[$];
  voxel_verdict_t verdict_q[$];
  int             items_sent = 0;
  int             errors = 0;
  int             quiet_cycles = 0;
  bit             send_idle = 1'b1;
  bit             recv_idle = 1'b1;
  int             starve_asked = 0;
  int             starve_seen = 0;
  int             send_gap = 0;
  int             recv_hold = 0;

  // Shadow of the block: two planes of classes, scan position and dimensions.
  logic [CLASS_W-1:0] class_planes [2][MAX_DIM][MAX_DIM];
  int dim_rows;
  int dim_cols;
  int dim_slices;
  int pos_row = 0;
  int pos_col = 0;
  int pos_slice = 0;

  volume_surface_voxel_finder_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .label_class(label_class),
    .flush      (flush),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row        (row),
    .col        (col),
    .slice      (slice),
    .on_boundary(on_boundary),
    .last_voxel (last_voxel)
  );

  always #5 clk = ~clk;

  // A dimension of zero acts as one; anything above the maximum acts as the maximum.
  function automatic int clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Takes one accepted voxel: decides the voxel one plane back, stores this one and
  // advances the scan position.
  function automatic void absorb_voxel(input logic [CLASS_W-1:0] cls_in, input logic pad_in);
    int r;
    int c;
    int si;
    int s;
    logic inside_vol;
    logic hit;
    logic [CLASS_W-1:0] cls;
    voxel_verdict_t v;
    r = pos_row;
    c = pos_col;
    si = pos_slice;
    inside_vol = si < dim_slices;
    cls = (pad_in || cls_in == CLASS_RSVD) ? CLASS_OTHER : cls_in;
    if (si >= 1) begin
      s = si - 1;
      hit = 1'b0;
      if (class_planes[s & 1][r][c] == CLASS_ONE) begin
        if (r + 1 < dim_rows && class_planes[s & 1][r + 1][c] == CLASS_ZERO) hit = 1'b1;
        if (r > 0 && class_planes[s & 1][r - 1][c] == CLASS_ZERO) hit = 1'b1;
        if (c + 1 < dim_cols && class_planes[s & 1][r][c + 1] == CLASS_ZERO) hit = 1'b1;
        if (c > 0 && class_planes[s & 1][r][c - 1] == CLASS_ZERO) hit = 1'b1;
        if (inside_vol && cls == CLASS_ZERO) hit = 1'b1;
        // The slot of the next plane still holds the previous plane at this position.
        if (s > 0 && class_planes[(s + 1) & 1][r][c] == CLASS_ZERO) hit = 1'b1;
      end
      v.row = COORD_W'(r);
      v.col = COORD_W'(c);
      v.slice = COORD_W'(s);
      v.on_boundary = hit;
      v.last_voxel = (r + 1 == dim_rows) && (c + 1 == dim_cols) && (s + 1 == dim_slices);
      verdict_q = {verdict_q, v};
    end
    if (inside_vol) class_planes[si & 1][r][c] = cls;
    pos_col = c + 1;
    if (pos_col >= dim_cols) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= dim_rows) begin
        pos_row = 0;
        pos_slice = si + 1;
        if (pos_slice > dim_slices) pos_slice = 0;
      end
    end
  endfunction

  function automatic void queue_voxel(input logic [CLASS_W-1:0] cls, input logic pad);
    voxel_item_t it;
    it.label = cls;
    it.padding = pad;
    feed_q = {feed_q, it};
    items_sent++;
  endfunction

  // Mostly ones and zeros so that boundaries are common.
  function automatic logic [CLASS_W-1:0] pick_class();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return CLASS_ONE;
    if (p < 80) return CLASS_ZERO;
    if (p < 93) return CLASS_OTHER;
    return CLASS_RSVD;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Waits until every queued voxel is taken and every expected result has come.
  task automatic settle();
    do @(negedge clk);
    while (feed_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Writes one register and mirrors it in the shadow; the block must be idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx != REG_UNUSED) begin
      case (idx)
        REG_ROWS: dim_rows = clamp_dim(val);
        REG_COLS: dim_cols = clamp_dim(val);
        default: dim_slices = clamp_dim(val);
      endcase
      pos_row = 0;
      pos_col = 0;
      pos_slice = 0;
    end
  endtask

  // Queues one volume and its flush plane, optionally pausing halfway until the
  // block drains, or cutting the volume off at a random point.
  task automatic queue_volume(input bit pause_midway, input bit cut_short);
    int vox;
    int cut;
    vox = dim_rows * dim_cols * dim_slices;
    cut = cut_short ? $urandom_range(1, vox) : vox + dim_rows * dim_cols;
    @(negedge clk);
    send_idle = $urandom_range(0, 2) != 0;
    recv_idle = $urandom_range(0, 2) != 0;
    for (int i = 0; i < cut; i++) begin
      if (pause_midway && i == cut / 2) settle();
      if (i < vox) begin
        queue_voxel(pick_class(), $urandom_range(0, 29) == 0);
      end else if ($urandom_range(0, 9) == 0) begin
        queue_voxel(pick_class(), 1'b0);
      end else begin
        queue_voxel(pick_class(), 1'b1);
      end
    end
  endtask

  // Sender: presents queued voxels with random gaps and holds each until taken.
  always @(posedge clk) begin
    voxel_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_voxel(label_class, flush);
        send_gap = send_idle ? $urandom_range(0, 11) : 0;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          nxt = feed_q.pop_front();
          in_valid <= 1'b1;
          label_class <= nxt.label;
          flush <= nxt.padding;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction against the oldest expectation and
  // stalls at random, or for a long stretch when asked.
  always @(posedge clk) begin
    voxel_verdict_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual row %0d col %0d slice %0d",
                   $time, row, col, slice);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          check_field("row", want.row, row);
          check_field("col", want.col, col);
          check_field("slice", want.slice, slice);
          check_field("on_boundary", want.on_boundary, on_boundary);
          check_field("last_voxel", want.last_voxel, last_voxel);
        end
        recv_hold = recv_idle ? $urandom_range(0, 11) : 0;
      end
      if (starve_seen != starve_asked) begin
        starve_seen = starve_asked;
        recv_hold = STARVE_CYCLES;
      end
      out_stall <= (recv_hold > 0);
      if (recv_hold > 0) recv_hold--;
    end
  end

  // Counts cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[volume_surface_voxel_finder_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    int shape;
    bit was_cut;
    bit cut_now;
    logic [CFG_W-1:0] rv;
    logic [CFG_W-1:0] cv;
    logic [CFG_W-1:0] sv;
    dim_rows = clamp_dim(DIM_RESET);
    dim_cols = clamp_dim(DIM_RESET);
    dim_slices = clamp_dim(DIM_RESET);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset dimensions: a few voxels of the first slice, which give no result.
    @(negedge clk);
    for (int i = 0; i < 5; i++) queue_voxel(pick_class(), 1'b0);
    settle();

    // A 2x2x2 volume with every class, a flush inside the volume and a plain
    // item inside the flush plane.
    write_reg(REG_ROWS, 7'd2);
    write_reg(REG_COLS, 7'd2);
    write_reg(REG_SLICES, 7'd2);
    @(negedge clk);
    queue_voxel(CLASS_ONE, 1'b0);
    queue_voxel(CLASS_ZERO, 1'b0);
    queue_voxel(CLASS_ONE, 1'b0);
    queue_voxel(CLASS_RSVD, 1'b0);
    queue_voxel(CLASS_ONE, 1'b0);
    queue_voxel(CLASS_ZERO, 1'b1);
    queue_voxel(CLASS_ZERO, 1'b0);
    queue_voxel(CLASS_ONE, 1'b0);
    queue_voxel(CLASS_OTHER, 1'b1);
    queue_voxel(CLASS_ZERO, 1'b0);
    queue_voxel(CLASS_ONE, 1'b1);
    queue_voxel(CLASS_RSVD, 1'b1);
    settle();

    // Zero dimensions act as one; the unused index changes nothing, so the second
    // single-voxel volume follows on the same counters.
    write_reg(REG_ROWS, 7'd0);
    write_reg(REG_COLS, 7'd0);
    write_reg(REG_SLICES, 7'd1);
    @(negedge clk);
    queue_voxel(CLASS_ONE, 1'b0);
    queue_voxel(CLASS_ONE, 1'b1);
    settle();
    write_reg(REG_UNUSED, 7'h7f);
    @(negedge clk);
    queue_voxel(CLASS_ZERO, 1'b0);
    queue_voxel(CLASS_ZERO, 1'b1);
    settle();

    // Random volumes: the three long extreme shapes first, then small shapes.
    was_cut = 1'b0;
    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      shape = (ph < 3) ? ph : 3;
      case (shape)
        0: begin
          rv = ($urandom_range(0, 1) != 0) ? 7'd64 : 7'h7f;
          cv = 7'd1;
          sv = 7'd2;
        end
        1: begin
          rv = 7'($urandom_range(0, 1));
          cv = ($urandom_range(0, 1) != 0) ? 7'd64 : 7'd100;
          sv = 7'd2;
        end
        2: begin
          rv = 7'd1;
          cv = 7'($urandom_range(0, 1));
          sv = 7'd64;
        end
        default: begin
          rv = 7'($urandom_range(1, 4));
          cv = 7'($urandom_range(1, 5));
          sv = 7'($urandom_range(1, 4));
        end
      endcase
      if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, 7'($urandom_range(0, 127)));
      // Now and then keep the dimensions and let the counters roll into the next volume.
      if (shape < 3 || was_cut || $urandom_range(0, 3) != 0) begin
        write_reg(REG_SLICES, sv);
        write_reg(REG_ROWS, rv);
        write_reg(REG_COLS, cv);
      end
      cut_now = (shape == 3) && ($urandom_range(0, 7) == 0);
      queue_volume(shape == 1 || $urandom_range(0, 4) == 0, cut_now);
      // Long receiver hold-off while the sender keeps offering the tall volume.
      if (shape == 0) starve_asked++;
      was_cut = cut_now;
      settle();
    end

    repeat (8) @(negedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("[volume_surface_voxel_finder_unit] OK");
    end else begin
      $display("[volume_surface_voxel_finder_unit] ERROR");
    end
    $finish;
  end

endmodule
